>>> src/tbx_pkg.sv
// Package for the tour block crossover: item and result types, geometry
// struct, command codes and sizing constants. No dependencies.
package tbx_pkg;

  localparam int MAX_POSITIONS = 64;
  localparam int POS_W         = 6;
  localparam int CITY_W        = 6;
  localparam int NUM_CITIES    = 1 << CITY_W;
  localparam int ADDR_W        = 3;
  localparam int DATA_W        = 32;

  localparam logic [POS_W-1:0] INTERIOR_MIN   = POS_W'(2);
  localparam logic [POS_W-1:0] INTERIOR_MAX   =
    POS_W'((MAX_POSITIONS - 2) < 62 ? (MAX_POSITIONS - 2) : 62);
  localparam logic [POS_W-1:0] INTERIOR_RESET = POS_W'(62);

  localparam logic [ADDR_W-3:0] REG_INTERIOR = '0;

  localparam logic [1:0] CMD_LOAD_A = 2'd0;
  localparam logic [1:0] CMD_LOAD_B = 2'd1;
  localparam logic [1:0] CMD_RUN    = 2'd2;

  typedef struct packed {
    logic [1:0]        command;
    logic [POS_W-1:0]  position;
    logic [CITY_W-1:0] city;
    logic [POS_W-1:0]  block_start;
  } item_t;

  typedef struct packed {
    logic [POS_W-1:0]  out_position;
    logic [CITY_W-1:0] out_city;
    logic              last;
    logic              error;
  } result_t;

  // run geometry derived from the interior count register
  typedef struct packed {
    logic [POS_W-1:0] n;
    logic [POS_W-1:0] len;
    logic [POS_W-1:0] max_start;
  } geom_t;

endpackage

>>> src/tbx_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tbx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/tbx_cfg.sv
// APB register for the interior count and the run geometry derived from it.
// Depends on tbx_pkg.
module tbx_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tbx_pkg::ADDR_W-1:0]    paddr,
  input  logic [tbx_pkg::DATA_W-1:0]    pwdata,
  output logic [tbx_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  output tbx_pkg::geom_t                geo
);

  logic [tbx_pkg::POS_W-1:0] interior_count;
  logic                      hit;
  logic [tbx_pkg::POS_W-1:0] n;
  logic [tbx_pkg::POS_W+1:0] n3;

  assign hit    = paddr[tbx_pkg::ADDR_W-1:2] == tbx_pkg::REG_INTERIOR;
  assign pready = 1'b1;
  assign prdata = hit ? tbx_pkg::DATA_W'(interior_count) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      interior_count <= tbx_pkg::INTERIOR_RESET;
    end else if (psel && penable && pwrite && hit) begin
      interior_count <= pwdata[tbx_pkg::POS_W-1:0];
    end
  end

  always_comb begin
    if (interior_count < tbx_pkg::INTERIOR_MIN) begin
      n = tbx_pkg::INTERIOR_MIN;
    end else if (interior_count > tbx_pkg::INTERIOR_MAX) begin
      n = tbx_pkg::INTERIOR_MAX;
    end else begin
      n = interior_count;
    end
    // 3n/4 as (2n + n) >> 2
    n3            = {1'b0, n, 1'b0} + {2'b00, n};
    geo.n         = n;
    geo.len       = n3[tbx_pkg::POS_W+1:2];
    geo.max_start = n + tbx_pkg::POS_W'(1) - n3[tbx_pkg::POS_W+1:2];
  end

endmodule

>>> src/tbx_seq.sv
// Crossover sequencer: marks parent A's block cities, then walks the child
// positions with one shared position counter and a parent B scan pointer.
// Depends on tbx_pkg; drives the read ports of the two parent RAMs.
module tbx_seq (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  tbx_pkg::item_t                 item,
  input  tbx_pkg::geom_t                 geo,
  output logic                           busy,
  output logic [tbx_pkg::POS_W-1:0]      a_raddr,
  input  logic [tbx_pkg::CITY_W-1:0]     a_rdata,
  output logic [tbx_pkg::POS_W-1:0]      b_raddr,
  input  logic [tbx_pkg::CITY_W-1:0]     b_rdata,
  output logic                           result_valid,
  output tbx_pkg::result_t               result
);

  typedef enum logic [1:0] {IDLE, FILL, EMIT_RD, EMIT_CK} state_t;

  state_t                         state;
  logic [tbx_pkg::POS_W-1:0]      pos;
  logic [tbx_pkg::POS_W-1:0]      j;
  logic [tbx_pkg::POS_W-1:0]      blk_start;
  logic [tbx_pkg::POS_W-1:0]      blk_end;
  logic                           pend;
  logic [tbx_pkg::NUM_CITIES-1:0] member;
  logic                           run_ok;
  logic                           run_bad;
  logic                           in_blk;
  logic                           exhausted;
  logic [tbx_pkg::POS_W-1:0]      pos_inc;
  logic [tbx_pkg::POS_W-1:0]      b_city;

  assign busy    = state != IDLE;
  assign a_raddr = pos;
  assign b_raddr = j;
  assign pos_inc = pos + tbx_pkg::POS_W'(1);

  always_comb begin
    run_bad   = 1'b0;
    run_ok    = 1'b0;
    if (start && !busy && item.command == tbx_pkg::CMD_RUN) begin
      if (item.block_start == '0 || item.block_start > geo.max_start) begin
        run_bad = 1'b1;
      end else begin
        run_ok = 1'b1;
      end
    end
    in_blk    = pos >= blk_start && pos < blk_end;
    exhausted = j > geo.n;
    b_city    = b_rdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      pend         <= 1'b0;
      member       <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      pend         <= state == FILL;
      if (pend) begin
        member[a_rdata] <= 1'b1;
      end
      case (state)
        IDLE: begin
          if (run_bad) begin
            result_valid <= 1'b1;
            result       <= '{out_position: '0, out_city: '0, last: 1'b1, error: 1'b1};
          end else if (run_ok) begin
            member    <= '0;
            blk_start <= item.block_start;
            blk_end   <= item.block_start + geo.len;
            pos       <= item.block_start;
            state     <= FILL;
          end
        end
        FILL: begin
          if (pos_inc == blk_end) begin
            pos   <= tbx_pkg::POS_W'(1);
            j     <= tbx_pkg::POS_W'(1);
            state <= EMIT_RD;
          end else begin
            pos <= pos_inc;
          end
        end
        EMIT_RD: begin
          state <= EMIT_CK;
        end
        EMIT_CK: begin
          if (!in_blk && !exhausted && member[b_city]) begin
            j     <= j + tbx_pkg::POS_W'(1);
            state <= EMIT_RD;
          end else begin
            result_valid        <= 1'b1;
            result.out_position <= pos;
            result.last         <= pos == geo.n;
            result.error        <= 1'b0;
            if (in_blk) begin
              result.out_city <= a_rdata;
            end else if (exhausted) begin
              result.out_city <= '0;
            end else begin
              result.out_city <= b_city;
              j               <= j + tbx_pkg::POS_W'(1);
            end
            if (pos == geo.n) begin
              state <= IDLE;
            end else begin
              pos   <= pos_inc;
              state <= EMIT_RD;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.error |-> result.last)
    else $error("error item without last");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> result_valid && result.last && !result.error)
    else $error("run ended without final item");

  a_pos_legal: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.error |-> result.out_position != '0
                                      && result.out_position <= geo.n)
    else $error("child position out of range");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    state == FILL |-> pos >= blk_start && pos < blk_end)
    else $error("block fill outside block");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == EMIT_RD || state == EMIT_CK |-> j <= geo.n + tbx_pkg::POS_W'(1))
    else $error("parent B scan overran");

endmodule

>>> src/tour_block_crossover.sv
// Top level of the tour block crossover: APB register, two parent RAMs and
// the crossover sequencer. Depends on tbx_pkg, tbx_cfg, tbx_ram, tbx_seq.
//
// Usage: an item is taken when start is high and busy is low.
//   command load A / load B writes city into that parent at position; busy
//   stays low, so loads can stream every cycle while no run is in progress.
//   command run builds the child over positions 1..n (n = clamped interior
//   count) and emits one result per position on result with result_valid
//   high for one cycle; last marks position n. Busy is high for the run.
//   A run with a bad block start gives one result (error and last set) the
//   cycle after it is taken; busy stays low.
// A run first marks the L block cities of parent A (L the block length,
//   3n/4), then for each child position reads the RAMs (EMIT_RD) and
//   compares (EMIT_CK), once more for each parent B city skipped; at most
//   L are skipped when both parents hold the same cities, at most n otherwise.
// Reset (rst, synchronous) returns the sequencer to idle and the interior
//   count to 62; parent contents are unknown until loaded.
// The receiver cannot stall: each result is valid for one cycle only.
// The interior count register sits at byte address 0; write it only idle.
module tour_block_crossover (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  tbx_pkg::item_t             item,
  output logic                       busy,
  output logic                       result_valid,
  output tbx_pkg::result_t           result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tbx_pkg::ADDR_W-1:0] paddr,
  input  logic [tbx_pkg::DATA_W-1:0] pwdata,
  output logic [tbx_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  tbx_pkg::geom_t               geo;
  logic [tbx_pkg::POS_W-1:0]    a_raddr;
  logic [tbx_pkg::POS_W-1:0]    b_raddr;
  logic [tbx_pkg::CITY_W-1:0]   a_rdata;
  logic [tbx_pkg::CITY_W-1:0]   b_rdata;
  logic                         take;
  logic                         we_a;
  logic                         we_b;

  assign take = start && !busy;
  assign we_a = take && item.command == tbx_pkg::CMD_LOAD_A;
  assign we_b = take && item.command == tbx_pkg::CMD_LOAD_B;

  tbx_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .geo     (geo)
  );

  tbx_ram #(.WIDTH(tbx_pkg::CITY_W), .DEPTH(tbx_pkg::MAX_POSITIONS)) u_parent_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (item.position),
    .wdata (item.city),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  tbx_ram #(.WIDTH(tbx_pkg::CITY_W), .DEPTH(tbx_pkg::MAX_POSITIONS)) u_parent_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (item.position),
    .wdata (item.city),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  tbx_seq u_seq (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .item         (item),
    .geo          (geo),
    .busy         (busy),
    .a_raddr      (a_raddr),
    .a_rdata      (a_rdata),
    .b_raddr      (b_raddr),
    .b_rdata      (b_rdata),
    .result_valid (result_valid),
    .result       (result)
  );

endmodule
